FILE: sv/dre_pkg.sv
// Shared constants and types of the delta row encoder.
`timescale 1ns / 1ps

package dre_pkg;

   // Row store and run geometry
   localparam int MAX_ROW_BYTES   = 1024;
   localparam int MAX_RUN         = 8;
   localparam int MAX_RESULTS     = 15;
   localparam int ADDR_W          = $clog2(MAX_ROW_BYTES);
   localparam int ROW_W           = 11;
   localparam int BYTE_W          = 8;
   localparam int RUN_LEN_W       = $clog2(MAX_RUN) + 1;
   localparam int RUN_IDX_W       = $clog2(MAX_RUN);
   localparam int CNT_W           = $clog2(MAX_RESULTS);
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = QPTR_W + 1;

   // Command byte fields
   localparam int OFF_FIELD_W     = 5;
   localparam int LEN_FIELD_W     = BYTE_W - OFF_FIELD_W;

   localparam logic [ROW_W-1:0]       ROW_BYTES_RESET = ROW_W'(877);
   localparam logic [OFF_FIELD_W-1:0] OFF_ESCAPE      = 5'h1f;
   localparam logic [BYTE_W-1:0]      EXT_FULL        = 8'hff;

   // One compressed run handed from the front end to the back end.  An
   // optional one-byte tail run follows when a new run opens on the row end.
   typedef struct packed {
      logic [RUN_LEN_W-1:0]            run_len;
      logic [ROW_W-1:0]                run_off;
      logic [MAX_RUN-1:0][BYTE_W-1:0]  run_data;
      logic                            has_tail;
      logic [ROW_W-1:0]                tail_off;
      logic [BYTE_W-1:0]               tail_byte;
      logic                            row_end;
   } job_type;

endpackage

FILE: sv/dre_req_if.sv
// Request channel: one raster byte with its first-row flag.
`timescale 1ns / 1ps

interface dre_req_if;
   import dre_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] pixel_byte;
   logic              first_row;

   modport source (output valid, output pixel_byte, output first_row, input ready);
   modport sink   (input valid, input pixel_byte, input first_row, output ready);
endinterface

FILE: sv/dre_rsp_if.sv
// Response channel: one compressed byte with its burst and row markers.
`timescale 1ns / 1ps

interface dre_rsp_if;
   import dre_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              burst_last;
   logic              row_end;

   modport source (output valid, output out_byte, output burst_last, output row_end,
                   input ready);
   modport sink   (input valid, input out_byte, input burst_last, input row_end,
                   output ready);
endinterface

FILE: sv/dre_front.sv
// Front end: row store lookup, change detection and run building.
`timescale 1ns / 1ps

module dre_front (
   input  logic                  clock,
   input  logic                  reset,
   dre_req_if.sink               req,
   input  logic [dre_pkg::ROW_W-1:0] row_bytes,
   input  logic                  q_full,
   output logic                  job_push,
   output dre_pkg::job_type      job
);
   import dre_pkg::*;

   logic [ADDR_W-1:0]               lenm1;
   logic                            at_end;
   logic [ADDR_W-1:0]               pos;
   logic                            accept;
   logic [ROW_W-1:0]                byte_pos_ff, byte_pos_in;

   logic [BYTE_W-1:0]               row_mem [MAX_ROW_BYTES];
   logic [BYTE_W-1:0]               prev_rd_ff;

   logic                            s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]               s1_byte_ff;
   logic                            s1_first_ff;
   logic                            s1_last_ff;
   logic                            s1_fire;

   logic [RUN_LEN_W-1:0]            run_len_ff, run_len_in;
   logic [ROW_W-1:0]                skip_off_ff, skip_off_in;
   logic                            run_open_ff, run_open_in;
   logic [ROW_W-1:0]                trail_ff, trail_in;
   logic [MAX_RUN-1:0][BYTE_W-1:0]  run_bytes_ff, run_bytes_in;

   logic [BYTE_W-1:0]               prev;
   logic                            changed;
   logic                            held_emit;
   logic                            extend;
   logic                            push_need;

   // Clamp the configured row length to the row store
   always_comb begin
      priority if (row_bytes == '0) begin
         lenm1 = '0;
      end else if (row_bytes > ROW_W'(MAX_ROW_BYTES)) begin
         lenm1 = ADDR_W'(MAX_ROW_BYTES - 1);
      end else begin
         lenm1 = ADDR_W'(row_bytes - ROW_W'(1));
      end
   end

   assign at_end      = (byte_pos_ff >= ROW_W'(lenm1));
   assign pos         = at_end ? lenm1 : byte_pos_ff[ADDR_W-1:0];
   assign accept      = req.valid && req.ready;
   assign byte_pos_in = at_end ? '0 : byte_pos_ff + ROW_W'(1);

   // Read the old byte and store the new one at the same place
   always_ff @(posedge clock) begin
      if (accept) begin
         row_mem[pos] <= req.pixel_byte;
         prev_rd_ff   <= row_mem[pos];
         s1_byte_ff   <= req.pixel_byte;
         s1_first_ff  <= req.first_row;
         s1_last_ff   <= at_end;
      end
   end

   // Classify the byte and build the next run state
   assign prev      = s1_first_ff ? '0 : prev_rd_ff;
   assign changed   = (s1_byte_ff != prev);
   assign held_emit = changed && (run_len_ff != '0) && !run_open_ff;
   assign extend    = changed && (run_len_ff != '0) && run_open_ff;

   always_comb begin
      run_len_in   = run_len_ff;
      skip_off_in  = skip_off_ff;
      run_open_in  = run_open_ff;
      trail_in     = trail_ff;
      run_bytes_in = run_bytes_ff;
      if (extend) begin
         run_bytes_in[run_len_ff[RUN_IDX_W-1:0]] = s1_byte_ff;
         run_len_in  = run_len_ff + RUN_LEN_W'(1);
         run_open_in = (run_len_ff != RUN_LEN_W'(MAX_RUN - 1));
      end else if (changed) begin
         run_bytes_in[0] = s1_byte_ff;
         run_len_in      = RUN_LEN_W'(1);
         run_open_in     = (MAX_RUN > 1);
         trail_in        = '0;
         if (held_emit) begin
            skip_off_in = trail_ff;
         end
      end else if (run_len_ff != '0) begin
         run_open_in = 1'b0;
         trail_in    = trail_ff + ROW_W'(1);
      end else begin
         skip_off_in = skip_off_ff + ROW_W'(1);
      end
   end

   // Hand a finished run, or the run closed by the row end, to the queue
   always_comb begin
      job.row_end   = s1_last_ff;
      job.tail_off  = trail_ff;
      job.tail_byte = s1_byte_ff;
      if (held_emit) begin
         job.run_len  = run_len_ff;
         job.run_off  = skip_off_ff;
         job.run_data = run_bytes_ff;
         job.has_tail = s1_last_ff;
      end else begin
         job.run_len  = run_len_in;
         job.run_off  = skip_off_in;
         job.run_data = run_bytes_in;
         job.has_tail = 1'b0;
      end
   end

   assign push_need   = held_emit || (s1_last_ff && (run_len_in != '0));
   assign s1_fire     = s1_valid_ff && !(push_need && q_full);
   assign job_push    = s1_valid_ff && push_need && !q_full;
   assign req.ready   = !s1_valid_ff || s1_fire;
   assign s1_valid_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= '0;
         s1_valid_ff <= 1'b0;
         run_len_ff  <= '0;
         skip_off_ff <= '0;
         run_open_ff <= 1'b0;
         trail_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            byte_pos_ff <= byte_pos_in;
         end
         if (s1_fire) begin
            if (s1_last_ff) begin
               run_len_ff  <= '0;
               skip_off_ff <= '0;
               run_open_ff <= 1'b0;
               trail_ff    <= '0;
            end else begin
               run_len_ff  <= run_len_in;
               skip_off_ff <= skip_off_in;
               run_open_ff <= run_open_in;
               trail_ff    <= trail_in;
            end
         end
      end
   end

   // Held run data
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         run_bytes_ff <= run_bytes_in;
      end
   end

endmodule

FILE: sv/dre_queue.sv
// Short run queue between the front end and the back end.
`timescale 1ns / 1ps

module dre_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dre_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output dre_pkg::job_type head_job
);
   import dre_pkg::*;

   job_type             q_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign head_job = q_mem[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem[wr_ptr_ff] <= push_job;
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

endmodule

FILE: sv/dre_back.sv
// Back end: serializes each run into command, offset extension and data bytes.
`timescale 1ns / 1ps

module dre_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  dre_pkg::job_type q_job,
   output logic             q_pop,
   dre_rsp_if.source        rsp
);
   import dre_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CMD  = 2'd1;
   localparam logic [1:0] ST_EXT  = 2'd2;
   localparam logic [1:0] ST_DATA = 2'd3;

   logic [1:0]           state_ff, state_in;
   job_type              job_ff, job_in;
   logic [ROW_W-1:0]     rem_ff, rem_in;
   logic [RUN_IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_end_ff, out_end_in;

   logic                 fire;
   logic                 nat_last;
   logic                 last;
   logic [RUN_LEN_W-1:0] len_m1;

   assign fire   = (state_ff != ST_IDLE) && (!out_valid_ff || rsp.ready);
   assign len_m1 = job_ff.run_len - RUN_LEN_W'(1);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      q_pop        = 1'b0;
      nat_last     = 1'b0;
      last         = 1'b0;

      // Drop the held byte once taken
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      if (fire) begin
         unique case (state_ff)
            ST_CMD: begin
               if (job_ff.run_off >= ROW_W'(OFF_ESCAPE)) begin
                  out_byte_in = {len_m1[LEN_FIELD_W-1:0], OFF_ESCAPE};
                  rem_in      = job_ff.run_off - ROW_W'(OFF_ESCAPE);
                  state_in    = ST_EXT;
               end else begin
                  out_byte_in = {len_m1[LEN_FIELD_W-1:0], job_ff.run_off[OFF_FIELD_W-1:0]};
                  idx_in      = '0;
                  state_in    = ST_DATA;
               end
            end
            ST_EXT: begin
               if (rem_ff >= ROW_W'(EXT_FULL)) begin
                  out_byte_in = EXT_FULL;
                  rem_in      = rem_ff - ROW_W'(EXT_FULL);
               end else begin
                  out_byte_in = rem_ff[BYTE_W-1:0];
                  idx_in      = '0;
                  state_in    = ST_DATA;
               end
            end
            ST_DATA: begin
               out_byte_in = job_ff.run_data[idx_ff];
               if (RUN_LEN_W'(idx_ff) == len_m1) begin
                  if (job_ff.has_tail) begin
                     // Move on to the one-byte run opened by the row end
                     job_in.run_len     = RUN_LEN_W'(1);
                     job_in.run_off     = job_ff.tail_off;
                     job_in.run_data[0] = job_ff.tail_byte;
                     job_in.has_tail    = 1'b0;
                     state_in           = ST_CMD;
                  end else begin
                     nat_last = 1'b1;
                  end
               end else begin
                  idx_in = idx_ff + RUN_IDX_W'(1);
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase

         // Cap the burst of one request at the result limit
         last         = nat_last || (cnt_ff == CNT_W'(MAX_RESULTS - 1));
         out_valid_in = 1'b1;
         out_last_in  = last;
         out_end_in   = last && job_ff.row_end;
         cnt_in       = cnt_ff + CNT_W'(1);
         if (last) begin
            state_in = ST_IDLE;
         end
      end

      // Load the next run when free
      if ((state_ff == ST_IDLE || (fire && last)) && q_valid) begin
         q_pop    = 1'b1;
         job_in   = q_job;
         cnt_in   = '0;
         state_in = ST_CMD;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.out_byte   = out_byte_ff;
   assign rsp.burst_last = out_last_ff;
   assign rsp.row_end    = out_end_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rem_ff      <= rem_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
   end

endmodule

FILE: sv/delta_row_encoder.sv
// Delta row encoder: raster rows in, delta-compressed byte stream out.
//
// Requests carry one raster byte and a first-row flag on req_ch; compressed
// bytes leave on rsp_ch, one per cycle while rsp_ch is ready, with burst_last
// on the final byte that a request causes and row_end on the final byte of a
// row. csr_we/csr_wdata set the row length in bytes (reset 877); write it only
// while idle. A request is taken every cycle while the run queue has room.
// The front end reads the row store in the accept cycle and classifies the byte
// in the following cycle; a completed run passes from the front-end stage
// registers through the run queue and the back end's command state to the
// rsp_ch output register. A run is held back until the next changed byte or
// the row end, so most requests produce nothing. The back end sends a run
// byte by byte, first loading it when idle; the four-entry run queue buffers
// runs, and a burst is capped at fifteen bytes. Reset clears the row position,
// the run state, the queue and the output register; the row store holds
// garbage until a row flagged first_row has been written. When rsp_ch stalls,
// the output byte holds, the queue fills and req_ch.ready then drops.
`timescale 1ns / 1ps

module delta_row_encoder (
   input  logic                        clock,
   input  logic                        reset,
   dre_req_if.sink                     req_ch,
   dre_rsp_if.source                   rsp_ch,
   input  logic                        csr_we,
   input  logic [dre_pkg::ROW_W-1:0]   csr_wdata
);
   import dre_pkg::*;

   logic [ROW_W-1:0] row_bytes_ff;
   logic             q_full;
   logic             job_push;
   job_type          push_job;
   logic             q_valid;
   job_type          head_job;
   logic             q_pop;

   // Row length register
   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= ROW_BYTES_RESET;
      end else if (csr_we) begin
         row_bytes_ff <= csr_wdata;
      end
   end

   dre_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .row_bytes (row_bytes_ff),
      .q_full    (q_full),
      .job_push  (job_push),
      .job       (push_job)
   );

   dre_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_job (head_job)
   );

   dre_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (head_job),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule
